@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/bmsw_pkg.sv @@
// ----------------------------------------------------------------------------
// bmsw_pkg
// Shared sizes, codes and types of the bilinear weight-map sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package bmsw_pkg;

  localparam int MAP_WIDTH  = 256;
  localparam int MAP_HEIGHT = 128;
  localparam int unsigned MAP_CELLS = MAP_WIDTH * MAP_HEIGHT;

  localparam int ADDR_W = $clog2(MAP_CELLS);
  localparam int COL_W  = $clog2(MAP_WIDTH);
  localparam int ROW_W  = $clog2(MAP_HEIGHT);

  // u*W + half fits here; v saturated to 1.0 is 17 bits
  localparam int SU_W = 16 + $clog2(MAP_WIDTH) + 1;
  localparam int SV_W = 17 + $clog2(MAP_HEIGHT) + 1;
  localparam int XP_W = SU_W - 16;
  localparam int YP_W = SV_W - 16;

  localparam int WGT_W  = 16;
  localparam int W_W    = 33;               // (1-f)*(1-g) up to 2^32
  localparam int PROD_W = WGT_W + W_W;
  localparam int ACC_W  = PROD_W + 1;

  localparam logic [WGT_W-1:0] ONE_Q15  = 16'h8000;
  localparam logic [16:0]      ONE_Q16  = 17'h10000;
  localparam logic [15:0]      HALF_Q16 = 16'h8000;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic CFG_MAP_ENABLED = 1'b0;
  localparam logic CFG_FALLBACK    = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDR,
    ST_READ,
    ST_MUL,
    ST_ACC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic       clr;
    logic       wgt_en;
    logic       mul_en;
    logic       acc_en;
    logic [1:0] sel;      // bit 0: right column, bit 1: lower row
  } blend_ctl_t;

  function automatic logic [WGT_W-1:0] sat_weight(input logic [WGT_W-1:0] w);
    sat_weight = (w > ONE_Q15) ? ONE_Q15 : w;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/bmsw_texmem.sv @@
// ----------------------------------------------------------------------------
// bmsw_texmem
// Texel store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bmsw_texmem (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [bmsw_pkg::ADDR_W-1:0] wr_addr,
  input  wire logic [bmsw_pkg::WGT_W-1:0]  wr_data,
  input  wire logic [bmsw_pkg::ADDR_W-1:0] rd_addr,
  output logic      [bmsw_pkg::WGT_W-1:0]  rd_data
);

  logic [bmsw_pkg::WGT_W-1:0] mem [bmsw_pkg::MAP_CELLS];
  logic [bmsw_pkg::WGT_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ rtl/core/bmsw_coord.sv @@
// ----------------------------------------------------------------------------
// bmsw_coord
// Coordinate front end: scales u and v, then derives the wrapped columns,
// clamped rows and the blend fractions.
// ----------------------------------------------------------------------------
`default_nettype none

module bmsw_coord (
  input  wire logic                       clk,
  input  wire logic                       load,
  input  wire logic                       step,
  input  wire logic [15:0]                u_coord,
  input  wire logic signed [17:0]         v_coord,
  output logic      [bmsw_pkg::COL_W-1:0] col0,
  output logic      [bmsw_pkg::COL_W-1:0] col1,
  output logic      [bmsw_pkg::ROW_W-1:0] row0,
  output logic      [bmsw_pkg::ROW_W-1:0] row1,
  output logic      [15:0]                fx,
  output logic      [15:0]                fy
);

  localparam int SU_W  = bmsw_pkg::SU_W;
  localparam int SV_W  = bmsw_pkg::SV_W;
  localparam int XP_W  = bmsw_pkg::XP_W;
  localparam int YP_W  = bmsw_pkg::YP_W;
  localparam int COL_W = bmsw_pkg::COL_W;
  localparam int ROW_W = bmsw_pkg::ROW_W;

  logic [16:0]     vsat;
  logic [SU_W-1:0] su_r, su_nxt;
  logic [SV_W-1:0] sv_r, sv_nxt;
  logic [XP_W-1:0] x0p, xm1;
  logic [YP_W-1:0] y0p, ym1;
  logic [COL_W-1:0] col0_r, col0_nxt, col1_r, col1_nxt;
  logic [ROW_W-1:0] row0_r, row0_nxt, row1_r, row1_nxt;
  logic [15:0]      fx_r, fy_r;

  // v saturated to [0, 1.0]
  assign vsat = v_coord[17] ? 17'd0 :
                (v_coord[16:0] > bmsw_pkg::ONE_Q16) ? bmsw_pkg::ONE_Q16 : v_coord[16:0];

  // offset of one whole unit folded in: -0.5 + 1.0 = +0.5
  assign su_nxt = SU_W'(u_coord) * SU_W'(bmsw_pkg::MAP_WIDTH) + SU_W'(bmsw_pkg::HALF_Q16);
  assign sv_nxt = SV_W'(vsat) * SV_W'(bmsw_pkg::MAP_HEIGHT) + SV_W'(bmsw_pkg::HALF_Q16);

  assign x0p = su_r[SU_W-1:16];
  assign xm1 = x0p - XP_W'(1);
  assign y0p = sv_r[SV_W-1:16];
  assign ym1 = y0p - YP_W'(1);

  assign col0_nxt = (x0p == '0 || xm1 >= XP_W'(bmsw_pkg::MAP_WIDTH)) ?
                    COL_W'(bmsw_pkg::MAP_WIDTH - 1) : COL_W'(xm1);
  assign col1_nxt = (col0_nxt == COL_W'(bmsw_pkg::MAP_WIDTH - 1)) ?
                    '0 : col0_nxt + COL_W'(1);

  assign row0_nxt = (y0p == '0) ? '0 :
                    (ym1 > YP_W'(bmsw_pkg::MAP_HEIGHT - 1)) ?
                    ROW_W'(bmsw_pkg::MAP_HEIGHT - 1) : ROW_W'(ym1);
  assign row1_nxt = (y0p > YP_W'(bmsw_pkg::MAP_HEIGHT - 1)) ?
                    ROW_W'(bmsw_pkg::MAP_HEIGHT - 1) : ROW_W'(y0p);

  always_ff @(posedge clk) begin
    if (load) begin
      su_r <= su_nxt;
      sv_r <= sv_nxt;
    end
    if (step) begin
      col0_r <= col0_nxt;
      col1_r <= col1_nxt;
      row0_r <= row0_nxt;
      row1_r <= row1_nxt;
      fx_r   <= su_r[15:0];
      fy_r   <= sv_r[15:0];
    end
  end

  assign col0 = col0_r;
  assign col1 = col1_r;
  assign row0 = row0_r;
  assign row1 = row1_r;
  assign fx   = fx_r;
  assign fy   = fy_r;

endmodule

`default_nettype wire

@@ rtl/core/bmsw_blend.sv @@
// ----------------------------------------------------------------------------
// bmsw_blend
// Shared weight multiplier, texel multiplier and accumulator; rounds and
// saturates the blended sum.
// ----------------------------------------------------------------------------
`default_nettype none

module bmsw_blend (
  input  wire logic                       clk,
  input  wire bmsw_pkg::blend_ctl_t       ctl,
  input  wire logic [15:0]                fx,
  input  wire logic [15:0]                fy,
  input  wire logic [bmsw_pkg::WGT_W-1:0] texel,
  output logic      [bmsw_pkg::WGT_W-1:0] result
);

  localparam int W_W    = bmsw_pkg::W_W;
  localparam int PROD_W = bmsw_pkg::PROD_W;
  localparam int ACC_W  = bmsw_pkg::ACC_W;

  logic [16:0]       gx, gy, wa, wb;
  logic [W_W-1:0]    w_r, w_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt, rnd;
  logic [ACC_W-33:0] q;

  assign gx = bmsw_pkg::ONE_Q16 - 17'(fx);
  assign gy = bmsw_pkg::ONE_Q16 - 17'(fy);
  assign wa = ctl.sel[0] ? 17'(fx) : gx;
  assign wb = ctl.sel[1] ? 17'(fy) : gy;

  assign w_nxt    = W_W'(wa) * W_W'(wb);
  assign prod_nxt = PROD_W'(texel) * PROD_W'(w_r);
  assign acc_nxt  = ctl.clr ? '0 : acc_r + ACC_W'(prod_r);

  always_ff @(posedge clk) begin
    if (ctl.wgt_en) begin
      w_r <= w_nxt;
    end
    if (ctl.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (ctl.clr || ctl.acc_en) begin
      acc_r <= acc_nxt;
    end
  end

  // round half up at bit 31, then clip to 1.0
  assign rnd    = acc_r + ACC_W'(33'h0_8000_0000);
  assign q      = rnd[ACC_W-1:32];
  assign result = (q > (ACC_W-32)'(bmsw_pkg::ONE_Q15)) ? bmsw_pkg::ONE_Q15 :
                  q[bmsw_pkg::WGT_W-1:0];

endmodule

`default_nettype wire

@@ rtl/core/bilinear_map_sampler_wrap_clamp.sv @@
// ----------------------------------------------------------------------------
// bilinear_map_sampler_wrap_clamp
// Bilinear weight-map sampler, u wrapping and v clamped, over one texel RAM.
// ----------------------------------------------------------------------------
// A write transaction stores one weight (clipped to 1.0). While the map is
// enabled, a sample transaction scales the coordinates on acceptance, forms
// the columns, rows and fractions, then handles the four corners in turn,
// each with a read through the single RAM read port and the weight multiply,
// then the texel multiply, then the accumulate, and finally rounds into the
// output register; no new input is taken before it finishes. With the map
// disabled a sample returns the fallback weight. The output register holds a
// result until it is taken; a sample waits in its final state while an
// earlier result is still stalled. The texel RAM has no reset and needs no
// clearing; only written texels may be sampled.
// ----------------------------------------------------------------------------
`default_nettype none

module bilinear_map_sampler_wrap_clamp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_opcode,
  input  wire logic [14:0]         in_texel_index,
  input  wire logic [15:0]         in_texel_value,
  input  wire logic [15:0]         in_u_coord,
  input  wire logic signed [17:0]  in_v_coord,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [15:0]              out_sampled_weight,
  input  wire logic                cfg_wr_en,
  input  wire logic [0:0]          cfg_index,
  input  wire logic [15:0]         cfg_data
);

  localparam int ADDR_W = bmsw_pkg::ADDR_W;

  bmsw_pkg::state_t     state_r, state_nxt;
  bmsw_pkg::blend_ctl_t ctl;

  logic        accept;
  logic        mem_wr_en, coord_load, coord_step, out_load;
  logic [1:0]  k_r, k_nxt;
  logic        fb_sel_r;
  logic        map_enabled_r;
  logic [15:0] fallback_weight_r;
  logic        out_valid_r;
  logic [15:0] out_weight_r;

  logic [bmsw_pkg::COL_W-1:0] col0, col1, col_sel;
  logic [bmsw_pkg::ROW_W-1:0] row0, row1, row_sel;
  logic [15:0]                fx, fy;
  logic [ADDR_W-1:0]          rd_addr;
  logic [bmsw_pkg::WGT_W-1:0] rd_data, blend_result;

  assign accept = in_valid && !in_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bmsw_pkg::ST_IDLE: begin
        if (accept && in_opcode == bmsw_pkg::OP_SAMPLE) begin
          state_nxt = map_enabled_r ? bmsw_pkg::ST_ADDR : bmsw_pkg::ST_DONE;
        end
      end
      bmsw_pkg::ST_ADDR: state_nxt = bmsw_pkg::ST_READ;
      bmsw_pkg::ST_READ: state_nxt = bmsw_pkg::ST_MUL;
      bmsw_pkg::ST_MUL:  state_nxt = bmsw_pkg::ST_ACC;
      bmsw_pkg::ST_ACC: begin
        state_nxt = (k_r == 2'd3) ? bmsw_pkg::ST_DONE : bmsw_pkg::ST_READ;
      end
      bmsw_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = bmsw_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bmsw_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall   = 1'b1;
    mem_wr_en  = 1'b0;
    coord_load = 1'b0;
    coord_step = 1'b0;
    out_load   = 1'b0;
    ctl        = '0;
    ctl.sel    = k_r;
    unique case (state_r)
      bmsw_pkg::ST_IDLE: begin
        in_stall   = 1'b0;
        mem_wr_en  = accept && in_opcode == bmsw_pkg::OP_WRITE &&
                     32'(in_texel_index) < bmsw_pkg::MAP_CELLS;
        coord_load = accept && in_opcode == bmsw_pkg::OP_SAMPLE;
      end
      bmsw_pkg::ST_ADDR: begin
        coord_step = 1'b1;
        ctl.clr    = 1'b1;
      end
      bmsw_pkg::ST_READ: ctl.wgt_en = 1'b1;
      bmsw_pkg::ST_MUL:  ctl.mul_en = 1'b1;
      bmsw_pkg::ST_ACC:  ctl.acc_en = 1'b1;
      bmsw_pkg::ST_DONE: out_load = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  assign k_nxt = (state_r == bmsw_pkg::ST_ACC) ? k_r + 2'd1 :
                 (state_r == bmsw_pkg::ST_ADDR) ? 2'd0 : k_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= bmsw_pkg::ST_IDLE;
      k_r               <= 2'd0;
      fb_sel_r          <= 1'b0;
      map_enabled_r     <= 1'b0;
      fallback_weight_r <= bmsw_pkg::ONE_Q15;
      out_valid_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      if (coord_load) begin
        fb_sel_r <= !map_enabled_r;
      end
      if (cfg_wr_en) begin
        unique case (cfg_index[0])
          bmsw_pkg::CFG_MAP_ENABLED: map_enabled_r     <= cfg_data[0];
          bmsw_pkg::CFG_FALLBACK:    fallback_weight_r <= cfg_data;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_weight_r <= fb_sel_r ? fallback_weight_r : blend_result;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_sampled_weight = out_weight_r;

  // corner k: bit 0 picks the right column, bit 1 the lower row
  assign col_sel = k_r[0] ? col1 : col0;
  assign row_sel = k_r[1] ? row1 : row0;
  assign rd_addr = ADDR_W'(row_sel) * ADDR_W'(bmsw_pkg::MAP_WIDTH) + ADDR_W'(col_sel);

  bmsw_coord u_coord (
    .clk     (clk),
    .load    (coord_load),
    .step    (coord_step),
    .u_coord (in_u_coord),
    .v_coord (in_v_coord),
    .col0    (col0),
    .col1    (col1),
    .row0    (row0),
    .row1    (row1),
    .fx      (fx),
    .fy      (fy)
  );

  bmsw_texmem u_texmem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (ADDR_W'(in_texel_index)),
    .wr_data (bmsw_pkg::sat_weight(in_texel_value)),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bmsw_blend u_blend (
    .clk    (clk),
    .ctl    (ctl),
    .fx     (fx),
    .fy     (fy),
    .texel  (rd_data),
    .result (blend_result)
  );

endmodule

`default_nettype wire

@@ rtl/core/bmsw_checker.sv @@
// ----------------------------------------------------------------------------
// bmsw_sva
// Port-level checks on the sampler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bmsw_sva (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               in_opcode,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [15:0]        out_sampled_weight
);

  logic acc_write, acc_sample;

  assign acc_write  = in_valid && !in_stall && in_opcode == bmsw_pkg::OP_WRITE;
  assign acc_sample = in_valid && !in_stall && in_opcode == bmsw_pkg::OP_SAMPLE;

  `ASSERT_ALWAYS(a_rst_clears_out, clk, !rst_n |=> !out_valid, "result valid after reset")
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "stalled result dropped")
  `ASSERT_CLK(a_out_stable, clk, rst_n, out_valid && out_stall |=> $stable(out_sampled_weight), "stalled result changed")
  `ASSERT_CLK(a_write_no_result, clk, rst_n, acc_write |=> !$rose(out_valid), "write produced a result")
  `ASSERT_CLK(a_sample_busy, clk, rst_n, acc_sample |=> in_stall, "input taken during a sample")

endmodule

bind bilinear_map_sampler_wrap_clamp bmsw_sva u_bmsw_sva (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .in_opcode          (in_opcode),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_sampled_weight (out_sampled_weight)
);

`default_nettype wire
